[rtl/quadratic_real_roots_defines.svh]
// ----------------------------------------------------------------------------
// Quadratic real roots: assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_REAL_ROOTS_DEFINES_SVH
`define QUADRATIC_REAL_ROOTS_DEFINES_SVH
`ifndef SYNTHESIS
`define QRR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QRR_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRR_ASSERT(label, clk, rst, prop, msg)
`define QRR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/qrr_pkg.sv]
// ----------------------------------------------------------------------------
// Quadratic real roots package
// Widths, status codes and the control word that travels down the chain.
// ----------------------------------------------------------------------------
`default_nettype none
package qrr_pkg;
  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEG     = 2'd1;
  localparam logic [1:0] ST_A_ZERO  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } qrr_ctl_t;
endpackage
`default_nettype wire

[rtl/qrr_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the digit-by-digit square root: takes two radicand
// bits, sets one root bit, and registers everything for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module qrr_sqrt_cell #(
  parameter int RW  = 34,  // radicand bits held (shifted left two per cell)
  parameter int QW  = 33,  // root width (remainder is two bits wider)
  parameter int PW  = 128  // width of side payload carried along
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire qrr_pkg::qrr_ctl_t ctl_in,
  input  wire logic [RW-1:0]     rad_in,
  input  wire logic [QW-1:0]     root_in,
  input  wire logic [QW+1:0]     rem_in,
  input  wire logic [PW-1:0]     pay_in,
  output qrr_pkg::qrr_ctl_t      ctl_out,
  output logic [RW-1:0]          rad_out,
  output logic [QW-1:0]          root_out,
  output logic [QW+1:0]          rem_out,
  output logic [PW-1:0]          pay_out
);
  import qrr_pkg::*;

  logic [QW+1:0] rem_sh;
  logic [QW+1:0] trial;
  logic          take;

  always_comb begin
    rem_sh = {rem_in[QW-1:0], rad_in[RW-1 -: 2]};
    trial  = {root_in, 2'b01};
    take   = rem_sh >= trial;
  end

  // Hold everything while the chain is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      rad_out  <= {rad_in[RW-3:0], 2'b00};
      root_out <= {root_in[QW-2:0], take};
      rem_out  <= take ? rem_sh - trial : rem_sh;
      pay_out  <= pay_in;
    end
  end
endmodule
`default_nettype wire

[rtl/qrr_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of an unsigned division for two quotients in parallel:
// shifts one dividend bit into each partial remainder and trial-subtracts.
// ----------------------------------------------------------------------------
`default_nettype none
module qrr_div_cell #(
  parameter int NW = 50,  // dividend / quotient width
  parameter int DW = 17,  // divisor width
  parameter int PW = 8    // side payload width
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire qrr_pkg::qrr_ctl_t ctl_in,
  input  wire logic [DW-1:0]     den_in,
  input  wire logic [NW-1:0]     qp_in,   // dividend bits shifting out, quotient in
  input  wire logic [DW:0]       rp_in,
  input  wire logic [NW-1:0]     qm_in,
  input  wire logic [DW:0]       rm_in,
  input  wire logic [PW-1:0]     pay_in,
  output qrr_pkg::qrr_ctl_t      ctl_out,
  output logic [DW-1:0]          den_out,
  output logic [NW-1:0]          qp_out,
  output logic [DW:0]            rp_out,
  output logic [NW-1:0]          qm_out,
  output logic [DW:0]            rm_out,
  output logic [PW-1:0]          pay_out
);
  import qrr_pkg::*;

  logic [DW+1:0] tp, tm;
  logic [DW+1:0] dx;

  always_comb begin
    dx = {1'b0, 1'b0, den_in};
    tp = {rp_in, qp_in[NW-1]};
    tm = {rm_in, qm_in[NW-1]};
  end

  // Hold everything while the chain is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      den_out <= den_in;
      pay_out <= pay_in;
      if (tp >= dx) begin
        rp_out <= DW'(tp - dx) == '0 ? '0 : (DW+1)'(tp - dx);
        qp_out <= {qp_in[NW-2:0], 1'b1};
      end else begin
        rp_out <= (DW+1)'(tp);
        qp_out <= {qp_in[NW-2:0], 1'b0};
      end
      if (tm >= dx) begin
        rm_out <= (DW+1)'(tm - dx);
        qm_out <= {qm_in[NW-2:0], 1'b1};
      end else begin
        rm_out <= (DW+1)'(tm);
        qm_out <= {qm_in[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/quadratic_real_roots.sv]
// ----------------------------------------------------------------------------
// Quadratic real roots
// Real roots of a*x^2+b*x+c in signed fixed point through a chain of square
// root cells and a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_axis   in   tdata: coef_a, coef_b, coef_c
//  m_axis   out  tdata: root_plus, root_minus, status
//
//  One item per cycle while m_axis does not stall; a result passes three front
//  stages, one cell per root bit, a numerator stage, one cell per quotient bit
//  and the output register. The chain advances whenever the output register
//  is empty or being taken; a stall on m_axis holds the whole chain and drops
//  s_axis_tready. Reset clears the valid bits along the chain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_real_roots_defines.svh"
module quadratic_real_roots #(
  parameter int COEF_BITS = qrr_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF,
  localparam int ROOT_BITS = COEF_BITS + FRAC_BITS + 2,
  localparam int IN_W  = ((3 * COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * ROOT_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // coef_a, coef_b, coef_c
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata    // root_plus, root_minus, status
);
  import qrr_pkg::*;

  localparam int DISC_BITS = 2 * COEF_BITS + 2;
  localparam int RAD_W = DISC_BITS + 2 * FRAC_BITS;   // even
  localparam int SQ_N  = RAD_W / 2;                   // root bits
  localparam int NUM_W = COEF_BITS + 1 + FRAC_BITS + 1; // |-b*2^F +/- s| bound
  localparam int NW    = (NUM_W > SQ_N + 1) ? NUM_W + 1 : SQ_N + 2;
  localparam int DW    = COEF_BITS + 1;
  localparam int SPW   = COEF_BITS + DW + 2;           // b, |2a|, sign of a, pad

  logic adv;
  // ---------------- stage 0: capture ----------------
  logic signed [COEF_BITS-1:0] a_in, b_in, c_in;
  assign a_in = s_axis_tdata[COEF_BITS-1:0];
  assign b_in = s_axis_tdata[2*COEF_BITS-1:COEF_BITS];
  assign c_in = s_axis_tdata[3*COEF_BITS-1:2*COEF_BITS];

  qrr_ctl_t ctl0;
  logic signed [COEF_BITS-1:0] a0, b0, c0;
  always_ff @(posedge clk) begin
    if (rst) ctl0 <= '0;
    else if (adv) ctl0 <= '{valid: s_axis_tvalid, status: ST_OK};
    if (adv) begin
      a0 <= a_in; b0 <= b_in; c0 <= c_in;
    end
  end

  // ---------------- stage 1: products ----------------
  qrr_ctl_t ctl1;
  logic signed [DISC_BITS-1:0] bb1, ac4;
  logic signed [COEF_BITS-1:0] a1, b1;
  always_ff @(posedge clk) begin
    if (rst) ctl1 <= '0;
    else if (adv) ctl1 <= '{valid: ctl0.valid,
                            status: (a0 == '0) ? ST_A_ZERO : ST_OK};
    if (adv) begin
      bb1 <= DISC_BITS'((2*COEF_BITS)'(b0) * (2*COEF_BITS)'(b0));
      ac4 <= DISC_BITS'((2*COEF_BITS)'(a0) * (2*COEF_BITS)'(c0)) <<< 2;
      a1 <= a0; b1 <= b0;
    end
  end

  // ---------------- stage 2: discriminant ----------------
  logic signed [DISC_BITS-1:0] disc;
  assign disc = bb1 - ac4;
  qrr_ctl_t ctl2;
  logic [RAD_W-1:0] rad2;
  logic [SPW-1:0]   pay2;
  always_ff @(posedge clk) begin
    if (rst) ctl2 <= '0;
    else if (adv) ctl2 <= '{valid: ctl1.valid,
      status: (ctl1.status == ST_A_ZERO) ? ST_A_ZERO :
              (disc[DISC_BITS-1] ? ST_NEG : ST_OK)};
    if (adv) begin
      rad2 <= {disc, {2*FRAC_BITS{1'b0}}};
      // |a| wraps to the right unsigned value for the most negative a
      pay2 <= {b1, DW'({(a1[COEF_BITS-1] ? -a1 : a1), 1'b0}),
               a1[COEF_BITS-1], 1'b0};
    end
  end

  // ---------------- square root chain ----------------
  qrr_ctl_t         sc [SQ_N+1];
  logic [RAD_W-1:0] sr [SQ_N+1];
  logic [SQ_N-1:0]  sq [SQ_N+1];
  logic [SQ_N+1:0]  sm [SQ_N+1];
  logic [SPW-1:0]   sp [SQ_N+1];
  assign sc[0] = ctl2;
  assign sr[0] = rad2;
  assign sq[0] = '0;
  assign sm[0] = '0;
  assign sp[0] = pay2;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    qrr_ctl_t         c_o;
    logic [RAD_W-1:0] r_o;
    logic [SQ_N-1:0]  q_o;
    logic [SQ_N+1:0]  m_o;
    logic [SPW-1:0]   p_o;
    qrr_sqrt_cell #(.RW(RAD_W), .QW(SQ_N), .PW(SPW)) u_cell (
      .clk, .rst, .en(adv),
      .ctl_in(sc[i]), .rad_in(sr[i]),
      .root_in(sq[i]), .rem_in(sm[i]),
      .pay_in(sp[i]),
      .ctl_out(c_o), .rad_out(r_o), .root_out(q_o), .rem_out(m_o), .pay_out(p_o)
    );
    assign sc[i+1] = c_o; assign sr[i+1] = r_o; assign sq[i+1] = q_o;
    assign sm[i+1] = m_o; assign sp[i+1] = p_o;
  end

  // ---------------- numerators (one stage) ----------------
  logic signed [COEF_BITS-1:0] bS;
  logic [DW-1:0] dS;
  logic          aneg;
  assign bS   = sp[SQ_N][SPW-1 -: COEF_BITS];
  assign dS   = sp[SQ_N][DW+1:2];
  assign aneg = sp[SQ_N][1];

  logic signed [NW:0] nb, np, nm;
  always_comb begin
    nb = -((NW+1)'(bS) <<< FRAC_BITS);
    np = nb + $signed({1'b0, (NW)'(sq[SQ_N])});
    nm = nb - $signed({1'b0, (NW)'(sq[SQ_N])});
  end

  qrr_ctl_t ctl3;
  logic [NW-1:0] up3, um3;
  logic [DW-1:0] d3;
  logic [1:0]    sg3; // result negative: plus, minus
  always_ff @(posedge clk) begin
    if (rst) ctl3 <= '0;
    else if (adv) ctl3 <= sc[SQ_N];
    if (adv) begin
      up3 <= NW'(np[NW] ? -np : np);
      um3 <= NW'(nm[NW] ? -nm : nm);
      d3  <= dS;
      sg3 <= {np[NW] ^ aneg, nm[NW] ^ aneg};
    end
  end

  // ---------------- divider chain ----------------
  qrr_ctl_t      dc [NW+1];
  logic [DW-1:0] dd [NW+1];
  logic [NW-1:0] qp [NW+1];
  logic [DW:0]   rp [NW+1];
  logic [NW-1:0] qm [NW+1];
  logic [DW:0]   rm [NW+1];
  logic [1:0]    dp [NW+1];
  assign dc[0] = ctl3; assign dd[0] = d3;
  assign qp[0] = up3;  assign rp[0] = '0;
  assign qm[0] = um3;  assign rm[0] = '0;
  assign dp[0] = sg3;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrr_ctl_t      c_o;
    logic [DW-1:0] d_o;
    logic [NW-1:0] qp_o, qm_o;
    logic [DW:0]   rp_o, rm_o;
    logic [1:0]    p_o;
    qrr_div_cell #(.NW(NW), .DW(DW), .PW(2)) u_cell (
      .clk, .rst, .en(adv),
      .ctl_in(dc[j]), .den_in(dd[j]),
      .qp_in(qp[j]), .rp_in(rp[j]),
      .qm_in(qm[j]), .rm_in(rm[j]),
      .pay_in(dp[j]),
      .ctl_out(c_o), .den_out(d_o), .qp_out(qp_o), .rp_out(rp_o),
      .qm_out(qm_o), .rm_out(rm_o), .pay_out(p_o)
    );
    assign dc[j+1] = c_o; assign dd[j+1] = d_o; assign qp[j+1] = qp_o;
    assign rp[j+1] = rp_o; assign qm[j+1] = qm_o; assign rm[j+1] = rm_o;
    assign dp[j+1] = p_o;
  end

  // ---------------- saturate and output ----------------
  localparam logic signed [NW+1:0] RMAX = (NW+2)'((64'sd1 <<< (ROOT_BITS-1)) - 1);
  localparam logic signed [NW+1:0] RMIN = -RMAX - 1;

  function automatic logic [ROOT_BITS-1:0] fit(input logic [NW-1:0] mag, input logic neg);
    logic signed [NW+1:0] v;
    v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (v > RMAX) v = RMAX;
    if (v < RMIN) v = RMIN;
    return v[ROOT_BITS-1:0];
  endfunction

  qrr_ctl_t fctl;
  logic ok;
  assign fctl = dc[NW];
  assign ok   = fctl.status == ST_OK;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= fctl.valid;
    if (adv) begin
      m_axis_tdata <= OUT_W'({fctl.status,
                              ok ? fit(qm[NW], dp[NW][0]) : {ROOT_BITS{1'b0}},
                              ok ? fit(qp[NW], dp[NW][1]) : {ROOT_BITS{1'b0}}});
    end
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  `QRR_ASSERT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped under stall")
  `QRR_ASSERT(a_stall_data, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed under stall")
  `QRR_ASSERT(a_no_st3, clk, rst, m_axis_tvalid |-> m_axis_tdata[2*ROOT_BITS +: 2] != 2'd3, "bad status code")
  `QRR_ASSERT_NR(a_rst_empty, clk, rst |=> !m_axis_tvalid, "valid after reset")
endmodule
`default_nettype wire

[sim/tb_quadratic_real_roots.sv]
// ----------------------------------------------------------------------------
// Quadratic real roots testbench
// Streams coefficient sets through the block with random gaps and stalls on
// both sides, predicts the two roots and the status of each set with an
// integer square root and a truncating divide, and checks every result in
// order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_real_roots;
  import qrr_pkg::*;

  localparam int CB = COEF_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int RB = CB + FB + 2;
  localparam int IN_W = ((3 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * RB + 2 + 7) / 8) * 8;
  localparam int DISC_W = 2 * CB + 2;
  localparam int LATENCY = 4 + (DISC_W + 2 * FB) / 2 + RB + 1;

  typedef struct packed {
    logic signed [CB-1:0] c;
    logic signed [CB-1:0] b;
    logic signed [CB-1:0] a;
  } coefs_t;

  typedef struct {
    logic [RB-1:0] plus;
    logic [RB-1:0] minus;
    logic [1:0]    status;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  coefs_t pending_sets[$];
  roots_t expected_roots[$];
  int mismatches = 0;
  int results_seen = 0;
  int drain_req = 0;
  bit stim_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;

  quadratic_real_roots i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Floor root of d * 4^FB, two bits per step.
  function automatic logic [63:0] frac_sqrt(input logic [63:0] d);
    logic [127:0] rem, trial, root;
    logic [127:0] dd;
    dd = {64'd0, d} << (2 * FB);
    rem = '0;
    root = '0;
    for (int i = (DISC_W + 2 * FB) / 2 - 1; i >= 0; i--) begin
      rem = (rem << 2) | ((dd >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 128'd1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic [RB-1:0] clamp_root(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (RB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[RB-1:0];
  endfunction

  function automatic roots_t solve_quadratic(input coefs_t s);
    roots_t r;
    longint a, b, c, disc, sq, nb, den;
    a = s.a;
    b = s.b;
    c = s.c;
    r.plus = '0;
    r.minus = '0;
    if (a == 0) begin
      r.status = ST_A_ZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.status = ST_NEG;
      return r;
    end
    sq = longint'(frac_sqrt(disc));
    nb = -b * (longint'(1) <<< FB);
    den = 2 * a;
    r.plus = clamp_root((nb + sq) / den);
    r.minus = clamp_root((nb - sq) / den);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CB-1:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p < 3) return CB'(int'($urandom_range(0, 40)) - 20);
    if (p == 3) return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
    return CB'($urandom);
  endfunction

  // Driver: hold an item until taken, then insert a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_sets.size() > 0 &&
                 !(drain_req > 0 && expected_roots.size() > (s_axis_tvalid ? 1 : 0))) begin
      coefs_t s;
      if (drain_req > 0 && !s_axis_tvalid) drain_req <= 0;
      s = pending_sets.pop_front();
      expected_roots.push_back(solve_quadratic(s));
      s_axis_tdata <= IN_W'(s);
      s_axis_tvalid <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Monitor: random stalls, compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        roots_t got, want;
        got.plus = m_axis_tdata[RB-1:0];
        got.minus = m_axis_tdata[2*RB-1:RB];
        got.status = m_axis_tdata[2*RB+1:2*RB];
        results_seen++;
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_roots.pop_front();
          if (got.plus !== want.plus || got.minus !== want.minus ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp plus %h minus %h st %0d, got %h %h %0d",
                       results_seen, want.plus, want.minus, want.status,
                       got.plus, got.minus, got.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    coefs_t s;
    logic signed [CB-1:0] ext[4];
    ext[0] = {1'b1, {(CB-1){1'b0}}};
    ext[1] = {1'b0, {(CB-1){1'b1}}};
    ext[2] = '0;
    ext[3] = '1;
    // Directed: extremes, coefficient a zero, negative discriminant, double root.
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 2) begin
        s.a = ext[i]; s.b = ext[j]; s.c = ext[3 - i];
        pending_sets.push_back(s);
      end
    s.a = CB'(1); s.b = CB'(0); s.c = CB'(1); pending_sets.push_back(s);
    s.a = CB'(1); s.b = CB'(-2); s.c = CB'(1); pending_sets.push_back(s);
    s.a = CB'(1); s.b = CB'(0); s.c = CB'(-2); pending_sets.push_back(s);
    s.a = CB'(-3); s.b = CB'(7); s.c = CB'(5); pending_sets.push_back(s);
    s.a = CB'(0); s.b = CB'(5); s.c = CB'(3); pending_sets.push_back(s);
    s.a = CB'(1); s.b = ext[0]; s.c = ext[0]; pending_sets.push_back(s);
    s.a = CB'(-1); s.b = ext[1]; s.c = ext[1]; pending_sets.push_back(s);
    s.a = CB'(1); s.b = CB'(0); s.c = CB'(0); pending_sets.push_back(s);
    for (int n = 0; n < 400; n++) begin
      s.a = rand_coef(); s.b = rand_coef(); s.c = rand_coef();
      pending_sets.push_back(s);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_sets.size() < 200);
    @(posedge clk);
    drain_req <= 1;
    wait (pending_sets.size() == 0 && s_axis_tvalid == 1'b0);
    wait (expected_roots.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d coefficient sets (extremes, zero a, negative and zero",
             results_seen);
    $display("discriminants, random) under random gaps and output stalls.");
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
